### rtl/rfbd_pkg.sv
// Package for the ring FIFO with burst drain: sizes, codes and shared types.
// No dependencies; every other file of the block but rfbd_ram imports it.
package rfbd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // fixed widths of the request and response fields
    localparam int ELEM_W  = 32;
    localparam int LIMIT_W = 8;
    localparam int OCNT_W  = 5;

    typedef enum logic {
        OP_OFFER = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_ACCEPT = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ZERO   = 2'd2,
        STAT_DRAIN  = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // port of the slot memory as driven by the controller
    typedef struct packed {
        logic                  we;
        logic [PTR_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [PTR_W-1:0]      raddr;
    } t_ram_req;

endpackage

### rtl/rfbd_if.sv
// Request and response channel interfaces (valid/ready) of the ring FIFO.
// Depends on rfbd_pkg.
interface rfbd_req_if;
    import rfbd_pkg::*;

    logic               valid;
    logic               ready;
    t_op                op;
    logic [ELEM_W-1:0]  element;
    logic [LIMIT_W-1:0] limit;

    modport source (output valid, output op, output element, output limit, input ready);
    modport sink   (input valid, input op, input element, input limit, output ready);
endinterface

interface rfbd_rsp_if;
    import rfbd_pkg::*;

    logic              valid;
    logic              ready;
    t_status           status;
    logic              has_element;
    logic [ELEM_W-1:0] popped_word;
    logic              last;
    logic [OCNT_W-1:0] drained_count;
    logic [OCNT_W-1:0] occupancy;

    modport source (output valid, output status, output has_element, output popped_word,
                    output last, output drained_count, output occupancy, input ready);
    modport sink   (input valid, input status, input has_element, input popped_word,
                    input last, input drained_count, input occupancy, output ready);
endinterface

### rtl/rfbd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module rfbd_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/rfbd_ctrl.sv
// Controller of the ring FIFO: pointers, fill count, drain sequencer and response register.
// Depends on rfbd_pkg and the channel interfaces; drives the slot memory.
module rfbd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rfbd_req_if.sink                      i_req,
    rfbd_rsp_if.source                    o_rsp,
    output rfbd_pkg::t_ram_req            o_ram,
    input  logic [rfbd_pkg::DATA_WIDTH-1:0] i_rdata
);
    import rfbd_pkg::*;

    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_wr_pos, n_wr_pos;
    logic [PTR_W-1:0] r_rd_pos, n_rd_pos;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_done, n_done;
    logic             r_out_valid, n_out_valid;

    t_status           r_status, n_status;
    logic              r_has, n_has;
    logic [ELEM_W-1:0] r_word, n_word;
    logic              r_last, n_last;
    logic [OCNT_W-1:0] r_dcnt, n_dcnt;
    logic [OCNT_W-1:0] r_occ, n_occ;

    logic                  out_free;
    logic                  load;
    logic                  accept;
    logic [DATA_WIDTH-1:0] in_word;
    logic [CNT_W-1:0]      take;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && out_free;
    assign accept = i_req.valid && i_req.ready;
    assign in_word = i_req.element[DATA_WIDTH-1:0];
    assign take = (CMP_W'(i_req.limit) < CMP_W'(r_fill)) ? CNT_W'(i_req.limit) : r_fill;

    always_comb begin
        n_state  = r_state;
        n_wr_pos = r_wr_pos;
        n_rd_pos = r_rd_pos;
        n_fill   = r_fill;
        n_left   = r_left;
        n_done   = r_done;
        n_status = r_status;
        n_has    = r_has;
        n_word   = r_word;
        n_last   = r_last;
        n_dcnt   = r_dcnt;
        n_occ    = r_occ;
        load     = 1'b0;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_wr_pos;
        o_ram.wdata = in_word;
        o_ram.re    = 1'b0;
        o_ram.raddr = r_rd_pos;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.op == OP_OFFER) begin
                        load   = 1'b1;
                        n_has  = 1'b0;
                        n_word = '0;
                        n_last = 1'b1;
                        n_dcnt = '0;
                        n_occ  = OCNT_W'(r_fill);
                        if (in_word == '0) begin
                            n_status = STAT_ZERO;
                        end else if (r_fill == CNT_W'(DEPTH)) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_status = STAT_ACCEPT;
                            o_ram.we = 1'b1;
                            n_wr_pos = r_wr_pos + 1'b1;
                            n_fill   = r_fill + 1'b1;
                            n_occ    = OCNT_W'(r_fill + 1'b1);
                        end
                    end else if (take == '0) begin
                        // nothing to pop: one empty drain response
                        load     = 1'b1;
                        n_status = STAT_DRAIN;
                        n_has    = 1'b0;
                        n_word   = '0;
                        n_last   = 1'b1;
                        n_dcnt   = '0;
                        n_occ    = OCNT_W'(r_fill);
                    end else begin
                        o_ram.re = 1'b1;
                        n_rd_pos = r_rd_pos + 1'b1;
                        n_left   = take;
                        n_done   = '0;
                        n_state  = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                // read data of the head word is valid here
                if (out_free) begin
                    load     = 1'b1;
                    n_status = STAT_DRAIN;
                    n_has    = 1'b1;
                    n_word   = ELEM_W'(i_rdata);
                    n_last   = (r_left == CNT_W'(1));
                    n_dcnt   = OCNT_W'(r_done + 1'b1);
                    n_occ    = OCNT_W'(r_fill - 1'b1);
                    n_fill   = r_fill - 1'b1;
                    n_done   = r_done + 1'b1;
                    n_left   = r_left - 1'b1;
                    if (r_left == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_ram.re = 1'b1;
                        n_rd_pos = r_rd_pos + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_pos    <= n_wr_pos;
            r_rd_pos    <= n_rd_pos;
            r_fill      <= n_fill;
            r_left      <= n_left;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_has    <= n_has;
        r_word   <= n_word;
        r_last   <= n_last;
        r_dcnt   <= n_dcnt;
        r_occ    <= n_occ;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.has_element   = r_has;
    assign o_rsp.popped_word   = r_word;
    assign o_rsp.last          = r_last;
    assign o_rsp.drained_count = r_dcnt;
    assign o_rsp.occupancy     = r_occ;
endmodule

### rtl/ring_fifo_with_burst_drain_core.sv
// Top level of the ring FIFO with burst drain.
// Depends on rfbd_pkg, rfbd_if, rfbd_ram and rfbd_ctrl.
//
// A 16-entry ring FIFO of 32-bit words with a valid/ready request channel and
// a valid/ready response channel. An offer request (op 0) stores a nonzero word
// and returns one response: accepted, full, or zero-word rejected (zero is
// refused even when full). A drain request (op 1) pops min(limit, occupancy)
// words oldest first, one response per word with last on the final one and a
// running drained_count; when nothing can be popped it returns one empty drain
// response. Every response carries the occupancy left after it. A drain first
// launches the read of the head word from the slot memory, which registers its
// read data, and then emits one word per cycle while the response side keeps
// ready high. A new request is taken only when the drain sequencer is idle and
// the response register is empty or being emptied in the same cycle. Slots are
// not cleared at reset: a slot is only read after it has been written. No
// clearing pass is needed after reset.
module ring_fifo_with_burst_drain_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rfbd_req_if.sink    i_req,
    rfbd_rsp_if.source  o_rsp
);
    import rfbd_pkg::*;

    t_ram_req              ram_req;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // sequencer: pointers, fill count and response register
    rfbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_ram   (ram_req),
        .i_rdata (ram_rdata)
    );

    // slot storage
    rfbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );
endmodule

### rtl/rfbd_checker.sv
// Port-level checks of the ring FIFO with burst drain, bound to the top level.
// Depends on rfbd_pkg.
module rfbd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input rfbd_pkg::t_status              i_status,
    input logic                           i_has_element,
    input logic [rfbd_pkg::ELEM_W-1:0]    i_popped_word,
    input logic                           i_last,
    input logic [rfbd_pkg::OCNT_W-1:0]    i_drained_count,
    input logic [rfbd_pkg::OCNT_W-1:0]    i_occupancy
);
    import rfbd_pkg::*;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_popped_word)
            && $stable(i_status) && $stable(i_last) && $stable(i_occupancy))
        else $error("response changed while stalled");

    // offer responses carry no word and end the request
    a_offer_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != STAT_DRAIN |->
            i_last && !i_has_element && i_drained_count == '0)
        else $error("malformed offer response");

    // a popped word is a stored nonzero word counted by the drain
    a_pop_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_has_element |->
            i_status == STAT_DRAIN && i_drained_count != '0 && i_popped_word != '0)
        else $error("malformed drained word");

    // occupancy never exceeds the ring size
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_occupancy <= OCNT_W'(DEPTH))
        else $error("occupancy out of range");

    // no new request is taken while a response is stuck
    a_no_take_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("request taken behind a stalled response");
endmodule

bind ring_fifo_with_burst_drain_core rfbd_checker u_rfbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_has_element   (o_rsp.has_element),
    .i_popped_word   (o_rsp.popped_word),
    .i_last          (o_rsp.last),
    .i_drained_count (o_rsp.drained_count),
    .i_occupancy     (o_rsp.occupancy)
);

### test/ring_fifo_with_burst_drain_core_test.sv
// Self-checking testbench for ring_fifo_with_burst_drain_core: a shadow FIFO predicts
// every response; directed, random and backpressure runs. Depends on rfbd_pkg, rfbd_if.
module ring_fifo_with_burst_drain_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfbd_pkg::*;

    typedef struct {
        t_status           status;
        logic              has_element;
        logic [ELEM_W-1:0] popped_word;
        logic              last;
        logic [OCNT_W-1:0] drained_count;
        logic [OCNT_W-1:0] occupancy;
    } t_fifo_rsp;

    logic i_clk;
    logic i_rst_n;

    rfbd_req_if req_bus ();
    rfbd_rsp_if rsp_bus ();

    ring_fifo_with_burst_drain_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the FIFO contents and pointers, advanced on each accepted request.
    logic [DATA_WIDTH-1:0] shadow_words [DEPTH];
    logic [PTR_W-1:0]      shadow_wr   = '0;
    logic [PTR_W-1:0]      shadow_rd   = '0;
    int                    shadow_fill = 0;

    // Responses predicted but not yet seen on the response channel, oldest first.
    t_fifo_rsp due_responses[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_cycles    = 0;   // receiver hold-off, counted down by the receiver process

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Work out the responses that one accepted request must produce.
    function automatic void predict_fifo_request(t_op op, logic [ELEM_W-1:0] word,
                                                 logic [LIMIT_W-1:0] lim);
        t_fifo_rsp r;
        int        pop_n;
        r.status        = STAT_ACCEPT;
        r.has_element   = 1'b0;
        r.popped_word   = '0;
        r.last          = 1'b1;
        r.drained_count = '0;
        if (op == OP_OFFER) begin
            // zero is refused ahead of the full check, so even a full FIFO reports it
            if (word == '0) begin
                r.status = STAT_ZERO;
            end else if (shadow_fill >= DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                shadow_words[shadow_wr] = word;
                shadow_wr   = shadow_wr + 1'b1;
                shadow_fill = shadow_fill + 1;
            end
            r.occupancy = shadow_fill[OCNT_W-1:0];
            due_responses.push_back(r);
        end else begin
            r.status = STAT_DRAIN;
            pop_n = (int'(lim) < shadow_fill) ? int'(lim) : shadow_fill;
            if (pop_n == 0) begin
                // empty FIFO or zero limit: a single empty drain response
                r.occupancy = shadow_fill[OCNT_W-1:0];
                due_responses.push_back(r);
            end else begin
                for (int k = 0; k < pop_n; k++) begin
                    r.has_element   = 1'b1;
                    r.popped_word   = shadow_words[shadow_rd];
                    shadow_rd       = shadow_rd + 1'b1;
                    shadow_fill     = shadow_fill - 1;
                    r.last          = (k == pop_n - 1);
                    r.drained_count = OCNT_W'(k + 1);
                    r.occupancy     = shadow_fill[OCNT_W-1:0];
                    due_responses.push_back(r);
                end
            end
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    // valid stays high between back-to-back requests and is only lowered for a gap.
    task automatic send_request(t_op op, logic [ELEM_W-1:0] word, logic [LIMIT_W-1:0] lim);
        if ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.op      <= op;
        req_bus.element <= word;
        req_bus.limit   <= lim;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        predict_fifo_request(op, word, lim);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every predicted response; ends on a falling edge.
    task automatic wait_until_drained();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (due_responses.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [ELEM_W-1:0] nonzero_word();
        logic [ELEM_W-1:0] w;
        w = $urandom;
        if (w == '0) w = 32'h1;
        return w;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Response checker: every accepted response against the oldest prediction.
    always @(posedge i_clk) begin : check_responses
        t_fifo_rsp want;
        if (i_rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (due_responses.size() == 0) begin
                $error("response with no request outstanding");
                mismatch_count++;
            end else begin
                want = due_responses.pop_front();
                compare_field("status", 32'(want.status), 32'(rsp_bus.status));
                compare_field("has_element", 32'(want.has_element), 32'(rsp_bus.has_element));
                compare_field("popped_word", want.popped_word, rsp_bus.popped_word);
                compare_field("last", 32'(want.last), 32'(rsp_bus.last));
                compare_field("drained_count", 32'(want.drained_count),
                              32'(rsp_bus.drained_count));
                compare_field("occupancy", 32'(want.occupancy), 32'(rsp_bus.occupancy));
            end
        end
    end

    // Response-side ready: random stalls, or a long forced hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Edge cases: empty drains, zero words, full FIFO, field extremes, drain-all.
    task automatic test_directed_cases();
        send_request(OP_DRAIN, 32'h0, 8'd5);            // drain when empty
        send_request(OP_DRAIN, 32'hFFFF_FFFF, 8'd0);    // zero limit, element ignored
        send_request(OP_OFFER, 32'h0, 8'hFF);           // zero word refused
        send_request(OP_OFFER, 32'h0000_0001, 8'd0);
        send_request(OP_OFFER, 32'hFFFF_FFFF, 8'd0);
        send_request(OP_OFFER, 32'h8000_0000, 8'd0);
        send_request(OP_OFFER, 32'hAAAA_AAAA, 8'd0);
        send_request(OP_OFFER, 32'h5555_5555, 8'd0);
        for (int k = 0; k < DEPTH - 5; k++) send_request(OP_OFFER, nonzero_word(), 8'd0);
        send_request(OP_OFFER, 32'h1234_5678, 8'd0);    // offer when full
        send_request(OP_OFFER, 32'h0, 8'd0);            // zero word wins over full
        send_request(OP_DRAIN, 32'h0, 8'd0);            // zero limit with words held
        send_request(OP_DRAIN, 32'h0, 8'd1);            // single pop
        send_request(OP_DRAIN, 32'h0, 8'hFF);           // limit saturates at occupancy
        wait_until_drained();
    endtask

    // Mostly offers and drains of random size; bursts of offers push the FIFO to full.
    task automatic test_random_traffic(int item_count);
        int sent;
        int pick;
        int burst_len;
        sent = 0;
        while (sent < item_count) begin
            pick = $urandom_range(99);
            if (pick < 7) begin
                burst_len = $urandom_range(14, 20);
                for (int k = 0; k < burst_len; k++)
                    send_request(OP_OFFER, nonzero_word(), LIMIT_W'($urandom));
                sent += burst_len;
            end else begin
                if (pick < 55)
                    send_request(OP_OFFER, nonzero_word(), LIMIT_W'($urandom));
                else if (pick < 60)
                    send_request(OP_OFFER, '0, LIMIT_W'($urandom));
                else if (pick < 80)
                    send_request(OP_DRAIN, $urandom, LIMIT_W'($urandom_range(1, 6)));
                else if (pick < 85)
                    send_request(OP_DRAIN, $urandom, 8'd0);
                else if (pick < 92)
                    send_request(OP_DRAIN, $urandom, LIMIT_W'($urandom_range(DEPTH, 255)));
                else
                    send_request(OP_DRAIN, $urandom, LIMIT_W'($urandom));
                sent++;
            end
        end
        wait_until_drained();
    endtask

    // Receiver holds off so that the request side stalls behind a response; DEPTH + 4
    // offers overfill the FIFO, a drain empties it, then all responses are awaited.
    task automatic test_backpressure_fill();
        @(posedge i_clk);
        hold_cycles = 200;
        @(negedge i_clk);
        for (int k = 0; k < DEPTH + 4; k++) send_request(OP_OFFER, nonzero_word(), 8'd0);
        send_request(OP_DRAIN, 32'h0, 8'hFF);
        wait_until_drained();
    endtask

    initial begin
        req_bus.valid   = 1'b0;
        req_bus.op      = OP_OFFER;
        req_bus.element = '0;
        req_bus.limit   = '0;
        rsp_bus.ready   = 1'b0;
        i_rst_n         = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // slow receiver first
        send_idle_pct = 11;
        recv_idle_pct = 70;
        test_directed_cases();
        test_random_traffic(150);
        test_backpressure_fill();

        // slow sender
        send_idle_pct = 70;
        recv_idle_pct = 11;
        test_random_traffic(150);

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(120);

        wait_until_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && due_responses.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
